>>> hw/rtl/hsocc_pkg.sv
`timescale 1ns / 1ps
package hsocc_pkg;

  localparam int unsigned VAL_W = 16;
  localparam int unsigned RAW_W = 18;
  localparam int unsigned SUM_W = 19;

  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_e;

endpackage

>>> hw/rtl/hsocc_ser_mul.sv
`timescale 1ns / 1ps
module hsocc_ser_mul #(
  parameter int unsigned WA = hsocc_pkg::VAL_W,
  parameter int unsigned WB = hsocc_pkg::VAL_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [WA-1:0]   a_i,
  input  logic [WB-1:0]   b_i,
  output logic            done_o,
  output logic [WA+WB-1:0] prod_o
);

  localparam int unsigned CW = $clog2(WB);

  logic [WA-1:0] a_q;
  logic [WA-1:0] hi_q;
  logic [WB-1:0] lo_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic [WA:0]   step_sum;

  // One multiplier bit per cycle, least significant first.
  assign step_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(WB - 1)) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (run_q) begin
      hi_q <= step_sum[WA:1];
      lo_q <= {step_sum[0], lo_q[WB-1:1]};
    end
  end

  assign done_o = !run_q;
  assign prod_o = {hi_q, lo_q};

endmodule

>>> hw/rtl/hsocc_ser_div.sv
`timescale 1ns / 1ps
module hsocc_ser_div #(
  parameter int unsigned DW = hsocc_pkg::SUM_W,
  parameter int unsigned QW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(QW);

  logic [DW:0]   rem_q;
  logic [DW-1:0] den_q;
  logic [QW-1:0] quot_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          ge;
  logic [DW:0]   rem_next;

  // Restoring division, one quotient bit per cycle. The numerator never
  // exceeds the divisor, so the partial remainder stays below twice it.
  assign ge       = rem_q >= {1'b0, den_q};
  assign rem_next = ge ? rem_q - {1'b0, den_q} : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(QW - 1)) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (run_q) begin
      rem_q  <= {rem_next[DW-1:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign done_o = !run_q;
  assign quot_o = quot_q;

endmodule

>>> hw/rtl/hmm_state_occupancy_top.sv
`timescale 1ns / 1ps
// A node passes through the states MUL, SUM and DIV; the 16 steps of the bit-serial
// multipliers and the FRAC_BITS + 1 steps of the restoring dividers set its duration.
// A new node is accepted only in IDLE, once the previous result has been written to the
// output register; a stalled output holds the block in DIV.
// Reset clears the stored occupancies and start_delete_prob to zero and empties
// the output register.
module hmm_state_occupancy_top #(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // start_delete_prob
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // begin_prob, prev_match_to_match, prev_match_to_delete,
  // prev_delete_to_match, prev_delete_to_delete, match_to_insert
  input  logic [95:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // first_node
  input  logic        s_axis_tlast,   // last_node
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // match_occ, insert_occ, delete_occ
);

  import hsocc_pkg::*;

  localparam int unsigned VB    = (FRAC_BITS > 16) ? FRAC_BITS : 16;
  localparam int unsigned CMP_W = (VB + 1 > RAW_W) ? VB + 1 : RAW_W;
  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned PW    = 2 * VAL_W;
  localparam int unsigned IPW   = RAW_W + VAL_W;
  localparam logic [VB:0]  ONE_V  = (VB + 1)'(1) << FRAC_BITS;
  localparam logic [PW:0]  HALF_P = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [IPW:0] HALF_I = (IPW + 1)'(1) << (FRAC_BITS - 1);

  function automatic val_t clamp16(input val_t v);
    return ({{(VB + 1 - VAL_W){1'b0}}, v} > ONE_V) ? ONE_V[VAL_W-1:0] : v;
  endfunction

  function automatic val_t qround(input logic [PW-1:0] p);
    logic [PW:0] t;
    t = ({1'b0, p} + HALF_P) >> FRAC_BITS;
    return t[VAL_W-1:0];
  endfunction

  state_e state_q;

  logic first_q;
  logic last_q;
  val_t begin_q;
  val_t tmi_q;
  val_t sdp_q;
  val_t pmm_q, pmd_q, pdm_q, pdd_q;
  logic sum_zero_q;
  val_t occ_m_q, occ_i_q, occ_d_q;
  logic out_valid_q;

  logic in_acc;
  logic fin;

  logic [3:0]    mul_done;
  logic [PW-1:0] prod_mm, prod_md, prod_dm, prod_dd;

  logic [RAW_W-1:0] raw_m;
  logic [RAW_W-1:0] raw_d;
  logic [RAW_W-1:0] raw_mc;
  logic [SUM_W-1:0] sum;
  logic             sum_start;

  logic           div_m_done, div_d_done, ins_done;
  logic [QW-1:0]  quot_m, quot_d;
  logic [IPW-1:0] prod_i;
  logic [IPW:0]   ins_round;
  logic [IPW:0]   ins_clamp;
  logic [31:0]    quot_m_x, quot_d_x;
  val_t           m_next, i_next, d_next;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign sum_start = state_q == ST_SUM;
  assign s_axis_tready = state_q == ST_IDLE;

  hsocc_ser_mul #(.WA(VAL_W), .WB(VAL_W)) u_mul_mm (
    .clk_i, .rst_ni, .start_i(in_acc), .a_i(occ_m_q),
    .b_i(clamp16(s_axis_tdata[31:16])), .done_o(mul_done[0]), .prod_o(prod_mm)
  );

  hsocc_ser_mul #(.WA(VAL_W), .WB(VAL_W)) u_mul_md (
    .clk_i, .rst_ni, .start_i(in_acc), .a_i(occ_m_q),
    .b_i(clamp16(s_axis_tdata[47:32])), .done_o(mul_done[1]), .prod_o(prod_md)
  );

  hsocc_ser_mul #(.WA(VAL_W), .WB(VAL_W)) u_mul_dm (
    .clk_i, .rst_ni, .start_i(in_acc), .a_i(occ_d_q),
    .b_i(clamp16(s_axis_tdata[63:48])), .done_o(mul_done[2]), .prod_o(prod_dm)
  );

  hsocc_ser_mul #(.WA(VAL_W), .WB(VAL_W)) u_mul_dd (
    .clk_i, .rst_ni, .start_i(in_acc), .a_i(occ_d_q),
    .b_i(clamp16(s_axis_tdata[79:64])), .done_o(mul_done[3]), .prod_o(prod_dd)
  );

  always_comb begin
    if (first_q) begin
      raw_m = RAW_W'(begin_q);
      raw_d = RAW_W'(clamp16(sdp_q));
    end else begin
      raw_m = RAW_W'(pmm_q) + RAW_W'(occ_i_q) + RAW_W'(pdm_q) + RAW_W'(begin_q);
      raw_d = RAW_W'(pmd_q) + RAW_W'(pdd_q);
    end
    sum    = SUM_W'(raw_m) + SUM_W'(raw_d);
    raw_mc = (CMP_W'(raw_m) > CMP_W'(ONE_V)) ? RAW_W'(ONE_V) : raw_m;
  end

  hsocc_ser_div #(.DW(SUM_W), .QW(QW)) u_div_m (
    .clk_i, .rst_ni, .start_i(sum_start), .num_i(SUM_W'(raw_m)), .den_i(sum),
    .done_o(div_m_done), .quot_o(quot_m)
  );

  hsocc_ser_div #(.DW(SUM_W), .QW(QW)) u_div_d (
    .clk_i, .rst_ni, .start_i(sum_start), .num_i(SUM_W'(raw_d)), .den_i(sum),
    .done_o(div_d_done), .quot_o(quot_d)
  );

  hsocc_ser_mul #(.WA(RAW_W), .WB(VAL_W)) u_mul_ins (
    .clk_i, .rst_ni, .start_i(sum_start), .a_i(raw_mc), .b_i(tmi_q),
    .done_o(ins_done), .prod_o(prod_i)
  );

  always_comb begin
    ins_round = ({1'b0, prod_i} + HALF_I) >> FRAC_BITS;
    ins_clamp = (ins_round > (IPW + 1)'(ONE_V)) ? (IPW + 1)'(ONE_V) : ins_round;
    quot_m_x  = 32'(quot_m);
    quot_d_x  = 32'(quot_d);
    if (first_q) begin
      m_next = begin_q;
      d_next = clamp16(sdp_q);
    end else if (sum_zero_q) begin
      m_next = '0;
      d_next = '0;
    end else begin
      m_next = quot_m_x[VAL_W-1:0];
      d_next = quot_d_x[VAL_W-1:0];
    end
    i_next = last_q ? '0 : ins_clamp[VAL_W-1:0];
  end

  assign fin = (state_q == ST_DIV) && div_m_done && div_d_done && ins_done &&
               (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (&mul_done) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (fin) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdp_q       <= '0;
      occ_m_q     <= '0;
      occ_i_q     <= '0;
      occ_d_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sdp_q <= cfg_wdata_i;
      end
      if (fin) begin
        occ_m_q     <= m_next;
        occ_i_q     <= i_next;
        occ_d_q     <= d_next;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      first_q <= s_axis_tuser;
      last_q  <= s_axis_tlast;
      begin_q <= clamp16(s_axis_tdata[15:0]);
      tmi_q   <= clamp16(s_axis_tdata[95:80]);
    end
    if ((state_q == ST_MUL) && (&mul_done)) begin
      pmm_q <= qround(prod_mm);
      pmd_q <= qround(prod_md);
      pdm_q <= qround(prod_dm);
      pdd_q <= qround(prod_dd);
    end
    if (sum_start) begin
      sum_zero_q <= sum == '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {occ_d_q, occ_i_q, occ_m_q};

  a_ready_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (&mul_done) && div_m_done && div_d_done && ins_done)
    else $error("input ready while a serial unit is still running");

  a_accept_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_MUL) && !mul_done[0])
    else $error("accepted transaction did not start the multipliers");

  a_last_no_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && last_q) |=> m_axis_tvalid && (m_axis_tdata[31:16] == '0))
    else $error("insert occupancy of the last node is not zero");

endmodule
